@@ rtl/msr_pkg.sv @@
// package: types, constants and register indexes for the slot reservation block
package msr_pkg;

  localparam int DEF_MAX_SLOTS = 32;

  typedef enum logic [2:0] {
    REG_TIMING_ENABLE   = 3'd0,
    REG_FE_SLOT_COUNT   = 3'd1,
    REG_CP_SLOT_COUNT   = 3'd2,
    REG_SUB_DEPTH_LIMIT = 3'd3,
    REG_CP_DEPTH_LIMIT  = 3'd4,
    REG_FE_SERVICE_TIME = 3'd5,
    REG_CP_SERVICE_TIME = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic        cmd;
    logic [63:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [63:0] done_time;
    logic [63:0] wait_time;
    logic [5:0]  busy_slots;
    logic        over_depth_hit;
    logic [63:0] served_so_far;
    logic [63:0] wait_sum;
    logic [63:0] wait_peak;
    logic [63:0] service_sum;
    logic [31:0] service_peak;
    logic [5:0]  busy_peak;
    logic [63:0] over_depth_so_far;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        pool;
    logic        enable;
    logic [63:0] arrival;
    logic [6:0]  slots;
    logic [15:0] limit;
    logic [31:0] service;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESERVE,
    ST_STATS,
    ST_OUT
  } state_t;

endpackage

@@ rtl/multi_server_slot_reservation.sv @@
// top level of the slot reservation block
// In the back end an item is taken from the queue, then a pipelined scan reads
// the chosen pool's free-time memory one slot per cycle, over the pool's clamped
// slot count, to find the earliest free slot and count busy slots; then one step
// each reserves, updates statistics and registers the result. With timing off
// the item goes from the scan straight to the statistics step. A two-entry queue
// lets the front accept items while the back works; a result that is not taken
// holds the back end in its last step. Reset clears the free times through
// per-slot valid bits.
module multi_server_slot_reservation #(
  parameter int MAX_SLOTS = msr_pkg::DEF_MAX_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  msr_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output msr_pkg::out_item_t out_item
);
  import msr_pkg::*;

  logic job_valid, job_take;
  job_t job;

  msr_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .push, .full, .in_item,
    .job_valid, .job_take, .job
  );

  msr_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk, .rst, .job_valid, .job_take, .job, .empty, .pop, .out_item
  );
endmodule

@@ rtl/msr_front.sv @@
// front: configuration registers, request classification and job queue
module msr_front #(
  parameter int MAX_SLOTS = msr_pkg::DEF_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              push,
  output logic              full,
  input  msr_pkg::in_item_t in_item,
  output logic              job_valid,
  input  logic              job_take,
  output msr_pkg::job_t     job
);
  import msr_pkg::*;

  logic        timing_enable;
  logic [5:0]  fe_count, cp_count;
  logic [15:0] sub_limit, cp_limit;
  logic [31:0] fe_service, cp_service;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timing_enable <= 1'b1;
      fe_count      <= 6'd3;
      cp_count      <= 6'd3;
      sub_limit     <= 16'd1024;
      cp_limit      <= 16'd1024;
      fe_service    <= 32'd5000;
      cp_service    <= 32'd4000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMING_ENABLE:   timing_enable <= cfg_data[0];
        REG_FE_SLOT_COUNT:   fe_count      <= cfg_data[5:0];
        REG_CP_SLOT_COUNT:   cp_count      <= cfg_data[5:0];
        REG_SUB_DEPTH_LIMIT: sub_limit     <= cfg_data[15:0];
        REG_CP_DEPTH_LIMIT:  cp_limit      <= cfg_data[15:0];
        REG_FE_SERVICE_TIME: fe_service    <= cfg_data;
        REG_CP_SERVICE_TIME: cp_service    <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify: clamp the slot count and select the pool's settings
  job_t        job_in;
  logic [5:0]  raw_count;
  always_comb begin
    raw_count = in_item.cmd ? cp_count : fe_count;
    job_in.pool    = in_item.cmd;
    job_in.enable  = timing_enable;
    job_in.arrival = in_item.arrival_time;
    if (raw_count == 6'd0) job_in.slots = 7'd1;
    else if ({1'b0, raw_count} > 7'(MAX_SLOTS)) job_in.slots = 7'(MAX_SLOTS);
    else job_in.slots = {1'b0, raw_count};
    job_in.limit   = in_item.cmd ? cp_limit : sub_limit;
    job_in.service = in_item.cmd ? cp_service : fe_service;
  end

  // two-entry job queue
  job_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  assign full      = cnt == 2'd2;
  assign job_valid = cnt != 2'd0;
  assign job       = q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) q[wp] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (job_take && job_valid) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(job_take && job_valid);
    end
  end
endmodule

@@ rtl/msr_back.sv @@
// back: slot scan, reservation, statistics and result register
module msr_back #(
  parameter int MAX_SLOTS = msr_pkg::DEF_MAX_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  msr_pkg::job_t      job,
  output logic               empty,
  input  logic               pop,
  output msr_pkg::out_item_t out_item
);
  import msr_pkg::*;

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  state_t state, state_next;

  // free-time stores, one memory per pool with a valid bit per entry
  logic [63:0] mem_fe [MAX_SLOTS];
  logic [63:0] mem_cp [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_fe, vld_cp;

  logic [63:0] count_served [2], total_wait [2], max_wait [2];
  logic [63:0] total_service [2], count_over [2];
  logic [31:0] max_service [2];
  logic [5:0]  max_busy [2];

  job_t          cur;
  logic [IW:0]   idx;
  logic [IW-1:0] best;
  logic [63:0]   best_t;
  logic [CW-1:0] busy;
  logic [63:0]   rd;
  logic          rd_ok;
  logic [IW:0]   rd_idx;
  logic [63:0]   wait_r, done_r;
  logic          hit_r;
  out_item_t     res;
  logic          res_full;

  // next state, timing off skips straight to the statistics step
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (job_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (!cur.enable) state_next = ST_STATS;
        else if (rd_idx == cur.slots[IW:0] - 1'b1 && rd_ok) state_next = ST_RESERVE;
      end
      ST_RESERVE: state_next = ST_STATS;
      ST_STATS:   state_next = ST_OUT;
      ST_OUT:     if (!res_full || pop) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_take = state == ST_IDLE && job_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // registered memory read, one slot per cycle
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && idx < cur.slots[IW:0]) begin
      if (cur.pool) rd <= vld_cp[idx[IW-1:0]] ? mem_cp[idx[IW-1:0]] : 64'd0;
      else          rd <= vld_fe[idx[IW-1:0]] ? mem_fe[idx[IW-1:0]] : 64'd0;
    end
  end

  // scan: earliest free slot and busy count
  always_ff @(posedge clk) begin
    if (job_take) begin
      cur   <= job;
      idx   <= '0;
      rd_ok <= 1'b0;
      busy  <= '0;
    end else if (state == ST_SCAN) begin
      if (idx < cur.slots[IW:0]) idx <= idx + 1'b1;
      rd_ok  <= idx < cur.slots[IW:0];
      rd_idx <= idx;
      if (rd_ok) begin
        if (rd_idx == '0 || rd < best_t) begin
          best   <= rd_idx[IW-1:0];
          best_t <= rd;
        end
        if (rd > cur.arrival) busy <= busy + 1'b1;
      end
    end
  end

  // reservation and slot write
  logic [63:0] start;
  assign start = best_t > cur.arrival ? best_t : cur.arrival;
  always_ff @(posedge clk) begin
    if (state == ST_RESERVE) begin
      wait_r <= start - cur.arrival;
      done_r <= start + {32'd0, cur.service};
      hit_r  <= cur.limit != 16'd0 && {{(16-CW){1'b0}}, busy} >= cur.limit;
      if (cur.pool) mem_cp[best] <= start + {32'd0, cur.service};
      else          mem_fe[best] <= start + {32'd0, cur.service};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_fe <= '0; vld_cp <= '0;
    end else if (state == ST_RESERVE) begin
      if (cur.pool) vld_cp[best] <= 1'b1;
      else          vld_fe[best] <= 1'b1;
    end
  end

  // per-pool statistics
  logic [5:0] busy6;
  assign busy6 = 6'(busy);
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 2; p++) begin
        count_served[p] <= '0; total_wait[p] <= '0; max_wait[p] <= '0;
        total_service[p] <= '0; count_over[p] <= '0; max_service[p] <= '0;
        max_busy[p] <= '0;
      end
    end else if (state == ST_STATS && cur.enable) begin
      count_served[cur.pool]  <= count_served[cur.pool] + 64'd1;
      total_wait[cur.pool]    <= total_wait[cur.pool] + wait_r;
      total_service[cur.pool] <= total_service[cur.pool] + {32'd0, cur.service};
      if (wait_r > max_wait[cur.pool]) max_wait[cur.pool] <= wait_r;
      if (cur.service > max_service[cur.pool]) max_service[cur.pool] <= cur.service;
      if (busy6 > max_busy[cur.pool]) max_busy[cur.pool] <= busy6;
      if (hit_r) count_over[cur.pool] <= count_over[cur.pool] + 64'd1;
    end
  end

  // result register
  assign empty    = !res_full;
  assign out_item = res;
  always_ff @(posedge clk) begin
    if (rst) res_full <= 1'b0;
    else if (state == ST_OUT && (!res_full || pop)) res_full <= 1'b1;
    else if (pop) res_full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!res_full || pop)) begin
      res.done_time         <= cur.enable ? done_r : cur.arrival;
      res.wait_time         <= cur.enable ? wait_r : 64'd0;
      res.busy_slots        <= cur.enable ? busy6 : 6'd0;
      res.over_depth_hit    <= cur.enable & hit_r;
      res.served_so_far     <= count_served[cur.pool];
      res.wait_sum          <= total_wait[cur.pool];
      res.wait_peak         <= max_wait[cur.pool];
      res.service_sum       <= total_service[cur.pool];
      res.service_peak      <= max_service[cur.pool];
      res.busy_peak         <= max_busy[cur.pool];
      res.over_depth_so_far <= count_over[cur.pool];
    end
  end
endmodule

@@ rtl/msr_checker.sv @@
// port checker for the slot reservation block, with its bind
module msr_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input msr_pkg::out_item_t out_item
);
  import msr_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item)) else $error("result dropped");

  // after reset nothing is waiting
  a_rst: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not empty after reset");

  // an over-depth hit always comes with busy slots
  a_hit: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.over_depth_hit |-> out_item.busy_slots != 6'd0)
    else $error("hit without busy slots");

  // wait peak never below the reported wait
  a_peak: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.wait_peak >= out_item.wait_time)
    else $error("wait above peak");
endmodule

bind multi_server_slot_reservation msr_checker u_chk (
  .clk, .rst, .full, .empty, .pop, .out_item
);
